// ===== sv/sha_pkg.sv =====
// Package for the SHA-256 hash engine: round constants, initial hash values,
// controller state type and the command struct. No dependencies.
package sha_pkg;

	localparam int unsigned Rounds     = 64;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic       wr_byte;     // write a byte into the block window
		logic [7:0] wr_data;
		logic [5:0] wr_addr;
		logic       wr_len;      // write the bit count byte for wr_addr instead
		logic       count_byte;  // add eight to the bit count
		logic       round_init;  // load working words from the hash
		logic       round_step;  // run one compression round
		logic [5:0] round_idx;
		logic       hash_update; // fold working words into the hash
		logic       hash_init;   // return to initial hash, clear bit count
		logic [2:0] out_idx;
	} sha_cmd_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k [0:63];
		k = '{
			32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
			32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
			32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
			32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
			32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
			32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
			32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
			32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
			32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
			32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
			32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h [0:7];
		h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
			32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
		return h[i];
	endfunction

endpackage

// ===== sv/sha_datapath.sv =====
// Datapath of the SHA-256 engine: bit counter, a 16-word block window that
// doubles as the message schedule, one shared round unit and the hash words.
// Depends on sha_pkg.
module sha_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::sha_cmd_t cmd,
	output logic [31:0]       digest_out
);

	logic [63:0] bits_q;
	logic [31:0] w_q [0:15];
	logic [31:0] s_q [0:7];
	logic [31:0] h_q [0:7];
	logic [31:0] x, y, s0, s1, w_new, t1, t2, e, a;
	logic [63:0] len_word;
	logic [7:0]  byte_data;

	// Message bit count modulo 2^64.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (cmd.hash_init) begin
			bits_q <= '0;
		end else if (cmd.count_byte) begin
			bits_q <= bits_q + 64'd8;
		end
	end

	// Byte to write: a message or pad byte, or a big-endian byte of the bit count.
	always_comb begin
		len_word  = bits_q >> {~cmd.wr_addr[2:0], 3'b000};
		byte_data = cmd.wr_len ? len_word[7:0] : cmd.wr_data;
	end

	// Round functions; the schedule shifts one word per round.
	always_comb begin
		x     = w_q[1];
		y     = w_q[14];
		s0    = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
		s1    = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		e     = s_q[4];
		a     = s_q[0];
		t1    = s_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & s_q[5]) ^ (~e & s_q[6])) + sha_pkg::round_k(cmd.round_idx) + w_q[0];
		t2    = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & s_q[1]) ^ (a & s_q[2]) ^ (s_q[1] & s_q[2]));
	end

	// Block window and schedule; byte 0 of a word is its most significant byte.
	always_ff @(posedge clk) begin
		if (cmd.round_step) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end else if (cmd.wr_byte) begin
			w_q[cmd.wr_addr[5:2]][{~cmd.wr_addr[1:0], 3'b000} +: 8] <= byte_data;
		end
	end

	// Working words.
	always_ff @(posedge clk) begin
		if (cmd.round_init) begin
			for (int i = 0; i < 8; i++) begin
				s_q[i] <= h_q[i];
			end
		end else if (cmd.round_step) begin
			s_q[7] <= s_q[6]; s_q[6] <= s_q[5]; s_q[5] <= s_q[4];
			s_q[4] <= s_q[3] + t1;
			s_q[3] <= s_q[2]; s_q[2] <= s_q[1]; s_q[1] <= s_q[0];
			s_q[0] <= t1 + t2;
		end
	end

	// Hash words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::init_h(3'(i));
			end
		end else if (cmd.hash_init) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::init_h(3'(i));
			end
		end else if (cmd.hash_update) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + s_q[i];
			end
		end
	end

	assign digest_out = h_q[cmd.out_idx];

endmodule

// ===== sv/sha_ctrl.sv =====
// Controller of the SHA-256 engine: byte loading, padding, round sequencing
// and digest emission. Depends on sha_pkg.
module sha_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_present,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_idx,
	output sha_pkg::sha_cmd_t cmd
);

	sha_pkg::ctrl_state_t state_q, state_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [5:0]  rnd_q, rnd_d;
	logic        fin_q, fin_d;     // 0x80 marker still owed
	logic        len_q, len_d;     // current padded block carries the length
	logic        close_q, close_d; // a message close is being processed
	logic [2:0]  oi_q, oi_d;

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_LOAD;
			cnt_q   <= '0;
			rnd_q   <= '0;
			fin_q   <= 1'b0;
			len_q   <= 1'b0;
			close_q <= 1'b0;
			oi_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rnd_q   <= rnd_d;
			fin_q   <= fin_d;
			len_q   <= len_d;
			close_q <= close_d;
			oi_q    <= oi_d;
		end
	end

	// Next state and commands. Padding writes one byte per cycle at cnt_q.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		rnd_d   = rnd_q;
		fin_d   = fin_q;
		len_d   = len_q;
		close_d = close_q;
		oi_d    = oi_q;
		cmd     = '0;
		cmd.round_idx = rnd_q;
		cmd.out_idx   = oi_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			sha_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_present) begin
						cmd.wr_byte    = 1'b1;
						cmd.wr_data    = in_byte;
						cmd.wr_addr    = cnt_q;
						cmd.count_byte = 1'b1;
						cnt_d = cnt_q + 6'd1;
					end
					if (in_last) begin
						fin_d   = 1'b1;
						close_d = 1'b1;
					end
					if (in_present && cnt_q == 6'd63) begin
						cmd.round_init = 1'b1;
						rnd_d   = '0;
						state_d = sha_pkg::ST_ROUND;
					end else if (in_last) begin
						state_d = sha_pkg::ST_PAD;
					end
				end
			end
			sha_pkg::ST_PAD: begin
				// The 0x80 marker first, then zeros, then the length in the last eight bytes.
				cmd.wr_byte = 1'b1;
				cmd.wr_addr = cnt_q;
				if (fin_q) begin
					cmd.wr_data = 8'h80;
					fin_d = 1'b0;
					// A marker at byte 56 or above pushes the length into another block.
					len_d = (cnt_q < 6'd56);
				end else if (len_q && cnt_q >= 6'd56) begin
					cmd.wr_len = 1'b1;
				end else begin
					cmd.wr_data = 8'h00;
				end
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					cmd.round_init = 1'b1;
					rnd_d   = '0;
					state_d = sha_pkg::ST_ROUND;
				end
			end
			sha_pkg::ST_ROUND: begin
				cmd.round_step = 1'b1;
				rnd_d = rnd_q + 6'd1;
				if (rnd_q == 6'(sha_pkg::Rounds - 1)) begin
					state_d = sha_pkg::ST_UPDATE;
				end
			end
			sha_pkg::ST_UPDATE: begin
				cmd.hash_update = 1'b1;
				cnt_d = '0;
				if (len_q) begin
					oi_d    = '0;
					state_d = sha_pkg::ST_EMIT;
				end else if (close_q) begin
					// Another padded block follows and it carries the length.
					len_d   = 1'b1;
					state_d = sha_pkg::ST_PAD;
				end else begin
					state_d = sha_pkg::ST_LOAD;
				end
			end
			sha_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					oi_d = oi_q + 3'd1;
					if (oi_q == 3'd7) begin
						cmd.hash_init = 1'b1;
						len_d   = 1'b0;
						fin_d   = 1'b0;
						close_d = 1'b0;
						state_d = sha_pkg::ST_LOAD;
					end
				end
			end
			default: state_d = sha_pkg::ST_LOAD;
		endcase
	end

	assign out_idx = oi_q;

	// Output is offered only while emitting.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == sha_pkg::ST_EMIT) else $error("valid outside emit");
	// No input taken while emitting.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while emitting");
	// A round run lasts until the last round index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::ST_ROUND && rnd_q != 6'd63) |=> state_q == sha_pkg::ST_ROUND)
		else $error("round run cut short");

endmodule

// ===== sv/sha256_hash_engine.sv =====
// Top level of the SHA-256 hash engine: controller plus datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
// Input channel s_axis: one transaction per item; tdata holds the message
// byte, tuser marks whether the byte belongs to the message, tlast closes
// the message. Output channel m_axis: eight transactions per message, the
// digest words H0..H7, with the word index in tuser and tlast on word 7.
// s_axis_tready is high in the load state; after the 64th byte of a block it
// stays low while the single shared round unit runs the 64 rounds and the
// hash words are updated. On a close the block is padded one byte per cycle
// from the fill level to byte 63, then compressed; when the length field
// does not fit, a second padded block is compressed as well. The first
// digest word is offered on the cycle after the last update, and one word
// moves per cycle while m_axis_tready is high. The
// output holds while m_axis_tready is low; no input is accepted until
// word 7 is taken, after which the hash words return to their initial values.
// Reset puts the initial hash values in place, clears counts, drops
// m_axis_tvalid and enters the idle load state with s_axis_tready high.
module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] byte_present
	input  logic        s_axis_tlast,  // end_of_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast   // last_word
);

	sha_pkg::sha_cmd_t cmd;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_byte(s_axis_tdata), .in_present(s_axis_tuser), .in_last(s_axis_tlast),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_idx(m_axis_tuser), .cmd(cmd)
	);

	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .digest_out(m_axis_tdata)
	);

	assign m_axis_tlast = (m_axis_tuser == 3'd7);

endmodule

// ===== test/tb_sha256_hash_engine.sv =====
// Self-checking testbench for the streaming SHA-256 hash engine.
// Depends on sha_pkg and sha256_hash_engine; a local digest model predicts every word.
`timescale 1ns / 100ps

class digest_scoreboard;
	bit [31:0] hash_state [8];
	bit [7:0]  block_bytes [64];
	int        fill_count;
	bit [63:0] bit_length;
	bit [31:0] expected_words [$];
	int        error_count;
	int        digests_seen;

	function new();
		restart();
		error_count = 0;
		digests_seen = 0;
	endfunction

	function void restart();
		hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		fill_count = 0;
		bit_length = '0;
	endfunction

	function bit [31:0] rotr(bit [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// One 64-round compression of the buffered block into the hash state.
	function void compress();
		bit [31:0] w [64];
		bit [31:0] s [8];
		bit [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		s = hash_state;
		for (int i = 0; i < 64; i++) begin
			t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
				+ ((s[4] & s[5]) ^ (~s[4] & s[6])) + sha_pkg::round_k(i[5:0]) + w[i];
			t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
				+ ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
			s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
			s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += s[i];
	endfunction

	// Notes an accepted input transaction and queues any digest it closes.
	function void note_input(bit [7:0] data, bit present, bit close);
		int pos;
		if (present) begin
			block_bytes[fill_count] = data;
			fill_count++;
			bit_length += 64'd8;
			if (fill_count == 64) begin
				compress();
				fill_count = 0;
			end
		end
		if (!close)
			return;
		pos = fill_count;
		block_bytes[pos++] = 8'h80;
		if (pos > 56) begin
			while (pos < 64) block_bytes[pos++] = 8'h00;
			compress();
			pos = 0;
		end
		while (pos < 56) block_bytes[pos++] = 8'h00;
		for (int i = 0; i < 8; i++)
			block_bytes[56+i] = bit_length[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++)
			expected_words.push_back(hash_state[i]);
		restart();
	endfunction

	// Compares one output transaction with the oldest expected word.
	function void check_word(bit [31:0] word, bit [2:0] index, bit last);
		bit [31:0] exp_word;
		bit [2:0]  exp_index;
		if (expected_words.size() == 0) begin
			$error("digest word 0x%08h arrived with nothing expected", word);
			error_count++;
			return;
		end
		exp_index = 3'(7 - ((expected_words.size() - 1) % 8));
		exp_word = expected_words.pop_front();
		if (word !== exp_word) begin
			$error("digest_word: expected 0x%08h, actual 0x%08h", exp_word, word);
			error_count++;
		end
		if (index !== exp_index) begin
			$error("word_index: expected %0d, actual %0d", exp_index, index);
			error_count++;
		end
		if (last !== (exp_index == 3'd7)) begin
			$error("last_word: expected %0b, actual %0b", exp_index == 3'd7, last);
			error_count++;
		end
		if (exp_index == 3'd7)
			digests_seen++;
	endfunction
endclass

module tb_sha256_hash_engine;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	digest_scoreboard board;
	int  bytes_sent;
	int  items_sent;
	bit  stimulus_done;

	sha256_hash_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Items left in the sender's current burst; a random gap, possibly none, comes before each burst.
	int burst_left;

	// Presents one transaction and holds it until accepted, with random gaps between bursts.
	task automatic send_item(bit [7:0] data, bit present, bit close);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= present;
		s_axis_tlast  <= close;
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(data, present, close);
		items_sent++;
		if (present)
			bytes_sent++;
	endtask

	// Sends a message of the given length with random content and a random close style.
	task automatic send_message(int len);
		bit sep_close;
		sep_close = (len == 0) || ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, !sep_close && (i == len - 1));
		end
		if (sep_close)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Receiver stalls in a pattern of its own: runs of random length, each ready or stalled at random.
	initial begin
		int run;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 12);
			m_axis_tready <= ($urandom_range(0, 2) != 0);
			repeat (run) @(posedge clk);
		end
	end

	// Output monitor.
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);

	initial begin
		int wait_cycles;
		board = new();
		bytes_sent = 0;
		items_sent = 0;
		burst_left = 0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, a no-op item, byte with close, extreme bytes,
		// and lengths around the padding boundary.
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		send_message(55);
		send_message(56);
		send_message(64);

		// Random messages: mostly short, some crossing block and padding boundaries.
		while (items_sent < 340) begin
			case ($urandom_range(0, 4))
				0: send_message($urandom_range(0, 3));
				1: send_message($urandom_range(52, 66));
				2: send_message($urandom_range(118, 130));
				default: send_message($urandom_range(0, 20));
			endcase
		end
		s_axis_tvalid <= 1'b0;
		stimulus_done = 1'b1;

		while (board.expected_words.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d digests over %0d items and %0d message bytes, with empty,",
			board.digests_seen, items_sent, bytes_sent);
		$display("no-op and two-block padding cases under random sender gaps and receiver stalls.");
		if (board.error_count == 0 && board.expected_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
